// ----- rtl/tsct_pkg.sv -----
// ----------------------------------------------------------------------------
// tsct_pkg: shared types and constants of the sleep countdown table
// Slot count, counter width and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package tsct_pkg;

  localparam int SLOTS       = 32;
  localparam int COUNT_WIDTH = 16;
  localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // function codes of an input transaction
  localparam logic FUNC_SET  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic accept_set;
    logic accept_tick;
    logic sweep;
    logic load_out;
  } tsct_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic last;
  } tsct_sts_t;

endpackage

// ----- rtl/task_sleep_countdown_table_top.sv -----
// ----------------------------------------------------------------------------
// task_sleep_countdown_table_top: sleep countdown table for task slots
// Keeps a sleep mask and one countdown per slot, reports woken slots on ticks.
// ----------------------------------------------------------------------------
// usage
//   input channel in_valid/in_ready carries in_func, in_slot, in_count.
//   a set transaction (func 0) stores a count for a slot and marks it asleep.
//   a tick transaction (func 1) decrements every sleeping nonzero count and
//   wakes every sleeping slot whose count is already zero.
//   each input transaction yields one result on out_valid/out_ready with
//   out_woken_mask and out_sleeping_mask.
// sequencing
//   a set passes from acceptance through the done state to the output register.
//   a tick runs one read-modify-write step of the countdown RAM per slot,
//   32 steps, set by the single write port of that RAM, then the done state.
//   a new transaction is accepted once the previous result sits in the
//   output register.
// reset and stall
//   reset clears the sleep mask and the output valid; countdowns need no
//   clearing since only the counts of sleeping slots are used.
//   while the receiver stalls, the result holds and one more transaction is
//   worked up to its result, then input ready stays low.
// ----------------------------------------------------------------------------
module task_sleep_countdown_table_top
  import tsct_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [4:0]  in_slot,
  input  logic [15:0] in_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_woken_mask,
  output logic [31:0] out_sleeping_mask
);

  tsct_cmd_t cmd;
  tsct_sts_t sts;

  // controller
  tsct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath
  tsct_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_slot           (in_slot),
    .in_count          (in_count),
    .cmd               (cmd),
    .sts               (sts),
    .out_woken_mask    (out_woken_mask),
    .out_sleeping_mask (out_sleeping_mask)
  );

endmodule

// ----- rtl/tsct_ram.sv -----
// ----------------------------------------------------------------------------
// tsct_ram: generic single write, single read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tsct_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ----- rtl/tsct_ctrl.sv -----
// ----------------------------------------------------------------------------
// tsct_ctrl: controller of the sleep countdown table
// Accepts transactions, runs the tick sweep and hands results to the
// output register.
// ----------------------------------------------------------------------------
module tsct_ctrl
  import tsct_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      in_func,
  output logic      out_valid,
  input  logic      out_ready,
  output tsct_cmd_t cmd,
  input  tsct_sts_t sts
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SWEEP = 3'b010,
    ST_DONE  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_fire;
  logic   out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt        = state_r;
    cmd.accept_set   = 1'b0;
    cmd.accept_tick  = 1'b0;
    cmd.sweep        = 1'b0;
    cmd.load_out     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_func == FUNC_TICK) begin
            cmd.accept_tick = 1'b1;
            state_nxt       = ST_SWEEP;
          end else begin
            cmd.accept_set = 1'b1;
            state_nxt      = ST_DONE;
          end
        end
      end
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/tsct_dp.sv -----
// ----------------------------------------------------------------------------
// tsct_dp: datapath of the sleep countdown table
// Sleep mask, countdown RAM, sweep index, woken mask and output registers.
// ----------------------------------------------------------------------------
module tsct_dp
  import tsct_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [4:0]  in_slot,
  input  logic [15:0] in_count,
  input  tsct_cmd_t   cmd,
  output tsct_sts_t   sts,
  output logic [31:0] out_woken_mask,
  output logic [31:0] out_sleeping_mask
);

  logic [SLOTS-1:0]       sleep_r, sleep_nxt;
  logic [SLOTS-1:0]       woken_r, woken_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [31:0]            woken_out_r, sleep_out_r;
  logic                   slot_ok;
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr, ram_raddr;
  logic [COUNT_WIDTH-1:0] ram_wdata, ram_rdata;
  logic                   cur_asleep;
  logic                   cur_zero;

  assign slot_ok    = (32'(in_slot) < 32'(SLOTS));
  assign cur_asleep = sleep_r[idx_r];
  assign cur_zero   = (ram_rdata == '0);
  assign sts.last   = (idx_r == IDX_W'(SLOTS - 1));

  // countdown store port control
  always_comb begin
    if (cmd.sweep) begin
      ram_we    = cur_asleep && !cur_zero;
      ram_waddr = idx_r;
      ram_wdata = ram_rdata - COUNT_WIDTH'(1);
      ram_raddr = idx_r + IDX_W'(1);
    end else begin
      ram_we    = cmd.accept_set && slot_ok;
      ram_waddr = IDX_W'(in_slot);
      ram_wdata = COUNT_WIDTH'(in_count);
      ram_raddr = '0;
    end
  end

  tsct_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // mask, woken and sweep index update
  always_comb begin
    sleep_nxt = sleep_r;
    woken_nxt = woken_r;
    idx_nxt   = idx_r;
    if (cmd.accept_set) begin
      woken_nxt = '0;
      if (slot_ok) begin
        sleep_nxt[IDX_W'(in_slot)] = 1'b1;
      end
    end
    if (cmd.accept_tick) begin
      woken_nxt = '0;
      idx_nxt   = '0;
    end
    if (cmd.sweep) begin
      idx_nxt = idx_r + IDX_W'(1);
      if (cur_asleep && cur_zero) begin
        woken_nxt[idx_r] = 1'b1;
        sleep_nxt[idx_r] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sleep_r <= '0;
    end else begin
      sleep_r <= sleep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    woken_r <= woken_nxt;
    idx_r   <= idx_nxt;
  end

  // output result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      woken_out_r <= 32'(woken_r);
      sleep_out_r <= 32'(sleep_r);
    end
  end

  assign out_woken_mask    = woken_out_r;
  assign out_sleeping_mask = sleep_out_r;

endmodule
